### design/deq_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the double-ended queue.
// No dependencies; used by the queue, its entry memory and its checker.
package deq_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int DATA_W       = 32;
    localparam int FILL_W       = 5;

    typedef enum logic [1:0] {
        OP_PUSH_BACK  = 2'd0,
        OP_POP_FRONT  = 2'd1,
        OP_PUSH_FRONT = 2'd2,
        OP_POP_BACK   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

endpackage

### design/double_ended_queue.sv
`timescale 1ns / 1ps
// Bounded double-ended queue kept in a circular buffer of CAPACITY words.
// Depends on deq_pkg and deq_ram.
//
// Usage: drive i_operation and i_value with start high; the item is taken
// at any edge where busy is low. busy stays low, so one item can be taken
// every cycle. In the cycle after an item is taken, o_valid is high for
// one cycle with o_status, o_popped_value and o_fill_level for that item.
// Throughput is one item per cycle: the front pointer and count are updated
// at the accepting edge, and the single synchronous read of the entry memory
// is launched at that same edge, so its registered data is ready in the
// result cycle.
// A push to a full queue reports full and a pop from an empty queue reports
// empty; neither changes anything, and popped_value is zero for them and
// for every push. o_fill_level shows the count held after the item.
// The receiver cannot stall; results must be taken in their strobe cycle.
// Reset empties the queue and clears the front pointer; the entry memory
// itself is not cleared, since a word is only read after it was written.
module double_ended_queue #(
    parameter int CAPACITY = deq_pkg::CAPACITY_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  logic [1:0]                             i_operation,
    input  logic signed [deq_pkg::DATA_W-1:0]      i_value,
    output logic                                   o_valid,
    output logic [1:0]                             o_status,
    output logic signed [deq_pkg::DATA_W-1:0]      o_popped_value,
    output logic [deq_pkg::FILL_W-1:0]             o_fill_level
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int SW = CW + 1;

    logic [AW-1:0]          r_front, n_front;
    logic [CW-1:0]          r_count, n_count;
    logic                   r_valid;
    deq_pkg::t_status       r_status, n_status;
    logic                   r_popped, n_popped;

    logic                   accept;
    deq_pkg::t_op           op;
    logic [SW-1:0]          sum_back;
    logic [SW-1:0]          sum_last;
    logic [AW-1:0]          slot_back;
    logic [AW-1:0]          slot_last;
    logic                   wr_en;
    logic                   rd_en;
    logic [AW-1:0]          wr_addr;
    logic [AW-1:0]          rd_addr;
    logic [deq_pkg::DATA_W-1:0] rd_data;

    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign op     = deq_pkg::t_op'(i_operation);

    assign sum_back  = SW'(r_front) + SW'(r_count);
    assign sum_last  = sum_back - SW'(1);
    assign slot_back = (sum_back >= SW'(CAPACITY)) ?
                       AW'(sum_back - SW'(CAPACITY)) : AW'(sum_back);
    assign slot_last = (sum_last >= SW'(CAPACITY)) ?
                       AW'(sum_last - SW'(CAPACITY)) : AW'(sum_last);

    always_comb begin
        n_front  = r_front;
        n_count  = r_count;
        n_status = deq_pkg::ST_OK;
        n_popped = 1'b0;
        wr_en    = 1'b0;
        rd_en    = 1'b0;
        wr_addr  = slot_back;
        rd_addr  = r_front;
        case (op)
            deq_pkg::OP_PUSH_BACK: begin
                if (r_count == CW'(CAPACITY)) begin
                    n_status = deq_pkg::ST_FULL;
                end else begin
                    wr_en   = accept;
                    wr_addr = slot_back;
                    n_count = r_count + CW'(1);
                end
            end
            deq_pkg::OP_PUSH_FRONT: begin
                if (r_count == CW'(CAPACITY)) begin
                    n_status = deq_pkg::ST_FULL;
                end else begin
                    n_front = (r_front == AW'(0)) ? AW'(CAPACITY - 1) : r_front - AW'(1);
                    wr_en   = accept;
                    wr_addr = n_front;
                    n_count = r_count + CW'(1);
                end
            end
            deq_pkg::OP_POP_FRONT: begin
                if (r_count == CW'(0)) begin
                    n_status = deq_pkg::ST_EMPTY;
                end else begin
                    rd_en    = accept;
                    rd_addr  = r_front;
                    n_popped = 1'b1;
                    n_front  = (r_front == AW'(CAPACITY - 1)) ? AW'(0) : r_front + AW'(1);
                    n_count  = r_count - CW'(1);
                end
            end
            deq_pkg::OP_POP_BACK: begin
                if (r_count == CW'(0)) begin
                    n_status = deq_pkg::ST_EMPTY;
                end else begin
                    rd_en    = accept;
                    rd_addr  = slot_last;
                    n_popped = 1'b1;
                    n_count  = r_count - CW'(1);
                end
            end
            default: begin
                n_status = deq_pkg::ST_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front  <= '0;
            r_count  <= '0;
            r_valid  <= 1'b0;
            r_status <= deq_pkg::ST_OK;
            r_popped <= 1'b0;
        end else begin
            r_valid <= accept;
            if (accept) begin
                r_front  <= n_front;
                r_count  <= n_count;
                r_status <= n_status;
                r_popped <= n_popped;
            end
        end
    end

    deq_ram #(
        .DEPTH(CAPACITY)
    ) u_ram (
        .i_clk    (i_clk),
        .i_wr_en  (wr_en),
        .i_wr_addr(wr_addr),
        .i_wr_data(i_value),
        .i_rd_en  (rd_en),
        .i_rd_addr(rd_addr),
        .o_rd_data(rd_data)
    );

    assign o_valid        = r_valid;
    assign o_status       = r_status;
    assign o_popped_value = r_popped ? rd_data : '0;
    assign o_fill_level   = deq_pkg::FILL_W'(r_count);

endmodule

### design/deq_ram.sv
`timescale 1ns / 1ps
// Entry store of the double-ended queue: one write port, one read port,
// registered read data. Uses deq_pkg for the data width.
module deq_ram #(
    parameter int DEPTH = deq_pkg::CAPACITY_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_wr_en,
    input  logic [$clog2(DEPTH)-1:0]          i_wr_addr,
    input  logic [deq_pkg::DATA_W-1:0]        i_wr_data,
    input  logic                              i_rd_en,
    input  logic [$clog2(DEPTH)-1:0]          i_rd_addr,
    output logic [deq_pkg::DATA_W-1:0]        o_rd_data
);

    logic [deq_pkg::DATA_W-1:0] r_mem [DEPTH];
    logic [deq_pkg::DATA_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### design/deq_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the double-ended queue, bound to its top level.
// Depends on deq_pkg for status codes and widths.
module deq_checker #(
    parameter int CAPACITY = deq_pkg::CAPACITY_DEF
) (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              start,
    input logic                              busy,
    input logic [1:0]                        i_operation,
    input logic                              o_valid,
    input logic [1:0]                        o_status,
    input logic [deq_pkg::DATA_W-1:0]        o_popped_value,
    input logic [deq_pkg::FILL_W-1:0]        o_fill_level
);

    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> o_valid)
        else $error("Accepted item produced no result.");

    a_no_extra: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(start && !busy) |=> !o_valid)
        else $error("Result strobe without an accepted item.");

    a_push_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_operation == deq_pkg::OP_PUSH_BACK ||
                            i_operation == deq_pkg::OP_PUSH_FRONT))
        |=> (o_popped_value == '0 && o_status != deq_pkg::ST_EMPTY))
        else $error("Push returned data or an empty status.");

    a_refused_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != deq_pkg::ST_OK)
        |-> (o_fill_level == $past(o_fill_level) && o_popped_value == '0))
        else $error("Refused item changed the fill level or returned data.");

    a_refused_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_status != deq_pkg::ST_EMPTY || o_fill_level == '0) &&
                     (o_status != deq_pkg::ST_FULL ||
                      o_fill_level == deq_pkg::FILL_W'(CAPACITY))))
        else $error("Refused item reported a fill level that does not match its status.");

endmodule

bind double_ended_queue deq_checker #(
    .CAPACITY(CAPACITY)
) u_deq_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .start         (start),
    .busy          (busy),
    .i_operation   (i_operation),
    .o_valid       (o_valid),
    .o_status      (o_status),
    .o_popped_value(o_popped_value),
    .o_fill_level  (o_fill_level)
);

### verif/double_ended_queue_checker.sv
`timescale 1ns / 1ps
// Checker for the double-ended queue: keeps its own copy of the deque, predicts each result.
// Depends on deq_pkg; instantiated beside the block by double_ended_queue_tb.
module double_ended_queue_checker #(
    parameter int CAPACITY = deq_pkg::CAPACITY_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic                              i_busy,
    input  logic [1:0]                        i_operation,
    input  logic signed [deq_pkg::DATA_W-1:0] i_value,
    input  logic                              i_valid,
    input  logic [1:0]                        i_status,
    input  logic signed [deq_pkg::DATA_W-1:0] i_popped_value,
    input  logic [deq_pkg::FILL_W-1:0]        i_fill_level,
    output int                                o_fail_count,
    output int                                o_pending,
    output int                                o_items,
    output int                                o_full_refusals,
    output int                                o_empty_refusals,
    output int                                o_peak_fill
);

    typedef struct {
        deq_pkg::t_status                  status;
        logic signed [deq_pkg::DATA_W-1:0] popped;
        logic [deq_pkg::FILL_W-1:0]        fill;
    } t_deq_result;

    logic signed [deq_pkg::DATA_W-1:0] deque_words [CAPACITY];
    int                                head_slot;
    int                                held_count;
    t_deq_result                       pending_results [$];

    function automatic t_deq_result apply_deque_op(
        deq_pkg::t_op op,
        logic signed [deq_pkg::DATA_W-1:0] word
    );
        t_deq_result res;
        res.status = deq_pkg::ST_OK;
        res.popped = '0;
        case (op)
            deq_pkg::OP_PUSH_BACK, deq_pkg::OP_PUSH_FRONT: begin
                if (held_count >= CAPACITY) begin
                    res.status = deq_pkg::ST_FULL;
                end else if (op == deq_pkg::OP_PUSH_BACK) begin
                    deque_words[(head_slot + held_count) % CAPACITY] = word;
                    held_count++;
                end else begin
                    head_slot = (head_slot + CAPACITY - 1) % CAPACITY;
                    deque_words[head_slot] = word;
                    held_count++;
                end
            end
            default: begin
                if (held_count == 0) begin
                    res.status = deq_pkg::ST_EMPTY;
                end else if (op == deq_pkg::OP_POP_FRONT) begin
                    res.popped = deque_words[head_slot];
                    head_slot = (head_slot + 1) % CAPACITY;
                    held_count--;
                end else begin
                    res.popped = deque_words[(head_slot + held_count - 1) % CAPACITY];
                    held_count--;
                end
            end
        endcase
        res.fill = held_count[deq_pkg::FILL_W-1:0];
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_deq_result exp_res;
        if (!i_rst_n) begin
            head_slot  = 0;
            held_count = 0;
            pending_results.delete();
            o_fail_count     <= 0;
            o_items          <= 0;
            o_full_refusals  <= 0;
            o_empty_refusals <= 0;
            o_peak_fill      <= 0;
        end else begin
            if (i_valid) begin
                if (pending_results.size() == 0) begin
                    if (o_fail_count < 10) begin
                        $display("%0t: result with no item waiting: status %0d popped %0d fill %0d",
                                 $realtime, i_status, i_popped_value, i_fill_level);
                    end
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    exp_res = pending_results.pop_front();
                    if (i_status !== exp_res.status || i_popped_value !== exp_res.popped
                            || i_fill_level !== exp_res.fill) begin
                        if (o_fail_count < 10) begin
                            $display("%0t: mismatch: status %0d/%0d popped %0d/%0d fill %0d/%0d",
                                     $realtime, exp_res.status, i_status, exp_res.popped,
                                     i_popped_value, exp_res.fill, i_fill_level);
                        end
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            if (i_start && !i_busy) begin
                exp_res = apply_deque_op(deq_pkg::t_op'(i_operation), i_value);
                pending_results.push_back(exp_res);
                o_items <= o_items + 1;
                if (exp_res.status == deq_pkg::ST_FULL) begin
                    o_full_refusals <= o_full_refusals + 1;
                end
                if (exp_res.status == deq_pkg::ST_EMPTY) begin
                    o_empty_refusals <= o_empty_refusals + 1;
                end
                if (held_count > o_peak_fill) begin
                    o_peak_fill <= held_count;
                end
            end
        end
        o_pending <= pending_results.size();
    end

endmodule

### verif/double_ended_queue_tb.sv
`timescale 1ns / 1ps
// Testbench top for the double-ended queue: clock, reset, directed and random items.
// Depends on deq_pkg, double_ended_queue and double_ended_queue_checker.
module double_ended_queue_tb;

    localparam int CAP = deq_pkg::CAPACITY_DEF;

    logic                              i_clk       = 1'b0;
    logic                              i_rst_n     = 1'b0;
    logic                              start       = 1'b0;
    logic                              busy;
    logic [1:0]                        i_operation = deq_pkg::OP_PUSH_BACK;
    logic signed [deq_pkg::DATA_W-1:0] i_value     = '0;
    logic                              o_valid;
    logic [1:0]                        o_status;
    logic signed [deq_pkg::DATA_W-1:0] o_popped_value;
    logic [deq_pkg::FILL_W-1:0]        o_fill_level;

    int fail_count;
    int pending;
    int items;
    int full_refusals;
    int empty_refusals;
    int peak_fill;
    int drain_fails = 0;

    double_ended_queue #(
        .CAPACITY(CAP)
    ) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_operation    (i_operation),
        .i_value        (i_value),
        .o_valid        (o_valid),
        .o_status       (o_status),
        .o_popped_value (o_popped_value),
        .o_fill_level   (o_fill_level)
    );

    double_ended_queue_checker #(
        .CAPACITY(CAP)
    ) u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_start          (start),
        .i_busy           (busy),
        .i_operation      (i_operation),
        .i_value          (i_value),
        .i_valid          (o_valid),
        .i_status         (o_status),
        .i_popped_value   (o_popped_value),
        .i_fill_level     (o_fill_level),
        .o_fail_count     (fail_count),
        .o_pending        (pending),
        .o_items          (items),
        .o_full_refusals  (full_refusals),
        .o_empty_refusals (empty_refusals),
        .o_peak_fill      (peak_fill)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    task automatic send_item(input deq_pkg::t_op op,
                             input logic signed [deq_pkg::DATA_W-1:0] word);
        start       <= 1'b1;
        i_operation <= op;
        i_value     <= word;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic sender_gap(input int idle_pct);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    function automatic logic signed [deq_pkg::DATA_W-1:0] pick_word();
        case ($urandom_range(9))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0000_0000;
            3: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    initial begin
        int idle_pct [4];
        int push_pct;
        int waited;
        bit is_push;
        bit at_back;

        idle_pct = '{0, 71, 0, 20};
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_item(deq_pkg::OP_POP_FRONT, 32'h1234_5678);
        send_item(deq_pkg::OP_POP_BACK, 32'hFFFF_FFFF);
        send_item(deq_pkg::OP_PUSH_BACK, 32'h7FFF_FFFF);
        send_item(deq_pkg::OP_PUSH_FRONT, 32'h8000_0000);
        send_item(deq_pkg::OP_PUSH_BACK, 32'h0000_0000);
        send_item(deq_pkg::OP_PUSH_FRONT, 32'hFFFF_FFFF);
        send_item(deq_pkg::OP_POP_FRONT, 32'h0);
        send_item(deq_pkg::OP_POP_BACK, 32'h0);
        for (int k = 0; k < 14; k++) begin
            send_item(k[0] ? deq_pkg::OP_PUSH_FRONT : deq_pkg::OP_PUSH_BACK,
                      k[1] ? 32'hAAAA_AAAA : 32'h5555_5555);
        end
        send_item(deq_pkg::OP_PUSH_BACK, 32'h0F0F_0F0F);
        send_item(deq_pkg::OP_PUSH_FRONT, 32'hF0F0_F0F0);

        push_pct = 50;
        for (int n = 0; n < 1326; n++) begin
            if (n % 40 == 0) begin
                case ($urandom_range(2))
                    0: push_pct = 85;
                    1: push_pct = 15;
                    default: push_pct = 50;
                endcase
            end
            sender_gap(idle_pct[(n / 200) % 4]);
            is_push = $urandom_range(99) < push_pct;
            at_back = 1'($urandom_range(1));
            if (is_push) begin
                send_item(at_back ? deq_pkg::OP_PUSH_BACK : deq_pkg::OP_PUSH_FRONT,
                          pick_word());
            end else begin
                send_item(at_back ? deq_pkg::OP_POP_BACK : deq_pkg::OP_POP_FRONT, $urandom);
            end
        end
        start <= 1'b0;

        waited = 0;
        while (pending != 0 && waited < 1000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (5) @(posedge i_clk);
        if (pending != 0) begin
            drain_fails = 1;
        end

        $display("Ran %0d items through the deque, peak fill %0d of %0d.",
                 items, peak_fill, CAP);
        $display("Refused pushes on full: %0d, refused pops on empty: %0d.",
                 full_refusals, empty_refusals);
        if (fail_count == 0 && drain_fails == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("FAIL");
        $finish;
    end

endmodule

### double_ended_queue.f
design/deq_pkg.sv
design/deq_ram.sv
design/double_ended_queue.sv
design/deq_checker.sv
verif/double_ended_queue_checker.sv
verif/double_ended_queue_tb.sv
